// ----- rtl/core/packet_impairment_shaper_assert.svh -----
// ----------------------------------------------------------------------------
// packet_impairment_shaper_assert.svh
// Assertion macros used by the packet impairment shaper top level.
// ----------------------------------------------------------------------------
`ifndef PACKET_IMPAIRMENT_SHAPER_ASSERT_SVH
`define PACKET_IMPAIRMENT_SHAPER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PIS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pis_pkg.sv -----
// ----------------------------------------------------------------------------
// pis_pkg
// Shared types and constants of the packet impairment shaper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pis_pkg;

    localparam int HOLD_DEPTH  = 10;
    localparam int CNT_W       = $clog2(HOLD_DEPTH + 1);
    localparam int PTR_W       = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [47:0] WINDOW_US = 48'd1000000;

    localparam logic [1:0] VERDICT_DROP    = 2'd0;
    localparam logic [1:0] VERDICT_HOLD    = 2'd1;
    localparam logic [1:0] VERDICT_RELEASE = 2'd2;

    localparam logic [1:0] REG_LOSS_TH    = 2'd0;
    localparam logic [1:0] REG_REORDER_TH = 2'd1;
    localparam logic [1:0] REG_BYTE_LIMIT = 2'd2;
    localparam logic [1:0] REG_DELAY      = 2'd3;

    typedef enum logic [1:0] {
        CMD_DROP,
        CMD_HOLD,
        CMD_RELEASE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [31:0] id;
        logic [47:0] rel_us;
    } cmd_t;

    typedef struct packed {
        logic [15:0] loss_th;
        logic [15:0] reorder_th;
        logic [31:0] byte_limit;
        logic [23:0] delay_us;
    } cfg_t;

endpackage

// ----- rtl/core/packet_impairment_shaper.sv -----
// ----------------------------------------------------------------------------
// packet_impairment_shaper
// Per-packet loss, byte budget, reorder and delay decisions.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one packet per transfer; m_axis carries verdicts, one
//   per transfer, tlast set on the final verdict caused by a packet.
//   A dropped or held packet gives one verdict; a released packet gives
//   one verdict per held packet (newest first) and then its own.
//   The classifier steps each packet through accept, budget window update
//   and decision, and takes no new packet until the decision is pushed.
//   The result sequencer emits one verdict per cycle while m_axis_tready is
//   high; a release with n held packets gives n + 1 verdicts on m_axis.
//   A 2-entry command queue sits between classifier and sequencer; the
//   classifier stalls only when it is full.
//   When m_axis_tready is low the current verdict holds in the output
//   register and the sequencer waits; packets are still taken until the
//   queue fills.
//   Reset empties the hold stack, clears the byte window and loads the
//   register defaults (byte_limit all ones, others zero).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "packet_impairment_shaper_assert.svh"

module packet_impairment_shaper
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pkt_id[31:0], arrival_us[79:32], payload_length[95:80],
    // loss_draw[111:96], reorder_draw[127:112]
    input  logic [127:0] s_axis_tdata,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_pkt_id[31:0], release_us[79:32]
    output logic [79:0]  m_axis_tdata,
    // verdict_kind[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    pis_pkg::cfg_t cfg_reg;

    logic          cfg_wr;
    logic          push_valid;
    logic          push_ready;
    pis_pkg::cmd_t push_cmd;
    logic          pop_valid;
    logic          pop_ready;
    pis_pkg::cmd_t pop_cmd;
    logic          queue_empty;

    logic [pis_pkg::CNT_W-1:0] front_cnt;
    logic [pis_pkg::CNT_W-1:0] back_cnt;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.loss_th    <= '0;
            cfg_reg.reorder_th <= '0;
            cfg_reg.byte_limit <= '1;
            cfg_reg.delay_us   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                pis_pkg::REG_LOSS_TH:    cfg_reg.loss_th    <= pwdata[15:0];
                pis_pkg::REG_REORDER_TH: cfg_reg.reorder_th <= pwdata[15:0];
                pis_pkg::REG_BYTE_LIMIT: cfg_reg.byte_limit <= pwdata;
                pis_pkg::REG_DELAY:      cfg_reg.delay_us   <= pwdata[23:0];
                default:                 cfg_reg.delay_us   <= cfg_reg.delay_us;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            pis_pkg::REG_LOSS_TH:    prdata = {16'd0, cfg_reg.loss_th};
            pis_pkg::REG_REORDER_TH: prdata = {16'd0, cfg_reg.reorder_th};
            pis_pkg::REG_BYTE_LIMIT: prdata = cfg_reg.byte_limit;
            pis_pkg::REG_DELAY:      prdata = {8'd0, cfg_reg.delay_us};
            default:                 prdata = '0;
        endcase
    end

    pis_front u_front
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .in_valid          (s_axis_tvalid),
        .in_ready          (s_axis_tready),
        .in_pkt_id         (s_axis_tdata[31:0]),
        .in_arrival_us     (s_axis_tdata[79:32]),
        .in_payload_length (s_axis_tdata[95:80]),
        .in_loss_draw      (s_axis_tdata[111:96]),
        .in_reorder_draw   (s_axis_tdata[127:112]),
        .push_valid        (push_valid),
        .push_ready        (push_ready),
        .push_cmd          (push_cmd),
        .held_cnt          (front_cnt)
    );

    pis_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .empty      (queue_empty)
    );

    pis_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (pop_valid),
        .cmd_ready  (pop_ready),
        .cmd        (pop_cmd),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res_kind   (m_axis_tuser),
        .res_id     (m_axis_tdata[31:0]),
        .res_rel_us (m_axis_tdata[79:32]),
        .res_last   (m_axis_tlast),
        .stack_cnt  (back_cnt)
    );

    `PIS_ASSERT_NOW(a_stack_in_sync, queue_empty, back_cnt == front_cnt,
        "hold stack depth differs from classifier count with queue empty")

    `PIS_ASSERT_NOW(a_held_bound, 1'b1,
        front_cnt <= pis_pkg::CNT_W'(pis_pkg::HOLD_DEPTH),
        "hold count above stack depth")

    `PIS_ASSERT_NOW(a_mid_run_release, m_axis_tvalid && !m_axis_tlast,
        m_axis_tuser == pis_pkg::VERDICT_RELEASE,
        "non-final verdict is not a release")

    `PIS_ASSERT_NEXT(a_front_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "classifier took a packet while busy")

endmodule

// ----- rtl/core/pis_front.sv -----
// ----------------------------------------------------------------------------
// pis_front
// Accepts packets, runs the loss, byte budget and reorder checks, and
// pushes one command per packet into the command queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pis_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pis_pkg::cfg_t          cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [31:0]            in_pkt_id,
    input  logic [47:0]            in_arrival_us,
    input  logic [15:0]            in_payload_length,
    input  logic [15:0]            in_loss_draw,
    input  logic [15:0]            in_reorder_draw,
    output logic                   push_valid,
    input  logic                   push_ready,
    output pis_pkg::cmd_t          push_cmd,
    output logic [pis_pkg::CNT_W-1:0] held_cnt
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_WINDOW,
        F_DECIDE
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [31:0] id_reg;
    logic [47:0] arr_reg;
    logic [15:0] len_reg;
    logic [15:0] ldraw_reg;
    logic [15:0] rdraw_reg;

    logic                      lost_reg, lost_next;
    logic [32:0]               win_bytes_reg, win_bytes_next;
    logic [47:0]               win_end_reg, win_end_next;
    logic [pis_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic        refresh;
    logic [48:0] end_sum;
    logic [32:0] bytes_base;
    logic [33:0] bytes_sum;
    logic        over_budget;
    logic        hold_ok;

    assign in_ready = (state_reg == F_IDLE);
    assign held_cnt = cnt_reg;

    assign refresh    = (arr_reg > win_end_reg);
    assign end_sum    = {1'b0, arr_reg} + {1'b0, pis_pkg::WINDOW_US};
    assign bytes_base = refresh ? 33'd0 : win_bytes_reg;
    assign bytes_sum  = {1'b0, bytes_base} + {18'd0, len_reg};

    assign over_budget = (win_bytes_reg > {1'b0, cfg.byte_limit});
    assign hold_ok     = (cnt_reg < pis_pkg::CNT_W'(pis_pkg::HOLD_DEPTH))
                       && (rdraw_reg < cfg.reorder_th);

    assign push_valid    = (state_reg == F_DECIDE);

    always_comb
    begin
        push_cmd.id     = id_reg;
        push_cmd.rel_us = arr_reg + {24'd0, cfg.delay_us};
        if (lost_reg || over_budget)
            push_cmd.op = pis_pkg::CMD_DROP;
        else if (hold_ok)
            push_cmd.op = pis_pkg::CMD_HOLD;
        else
            push_cmd.op = pis_pkg::CMD_RELEASE;
    end

    always_comb
    begin
        state_next     = state_reg;
        lost_next      = lost_reg;
        win_bytes_next = win_bytes_reg;
        win_end_next   = win_end_reg;
        cnt_next       = cnt_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                    state_next = F_WINDOW;
            end
            F_WINDOW:
            begin
                lost_next  = (ldraw_reg < cfg.loss_th);
                state_next = F_DECIDE;
                if (!(ldraw_reg < cfg.loss_th))
                begin
                    if (refresh)
                        win_end_next = end_sum[48] ? '1 : end_sum[47:0];
                    win_bytes_next = bytes_sum[33] ? '1 : bytes_sum[32:0];
                end
            end
            F_DECIDE:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                    if (push_cmd.op == pis_pkg::CMD_HOLD)
                        cnt_next = cnt_reg + 1'b1;
                    else if (push_cmd.op == pis_pkg::CMD_RELEASE)
                        cnt_next = '0;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            lost_reg      <= 1'b0;
            win_bytes_reg <= '0;
            win_end_reg   <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            lost_reg      <= lost_next;
            win_bytes_reg <= win_bytes_next;
            win_end_reg   <= win_end_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            id_reg    <= in_pkt_id;
            arr_reg   <= in_arrival_us;
            len_reg   <= in_payload_length;
            ldraw_reg <= in_loss_draw;
            rdraw_reg <= in_reorder_draw;
        end
    end

endmodule

// ----- rtl/core/pis_queue.sv -----
// ----------------------------------------------------------------------------
// pis_queue
// Small command FIFO between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pis_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  pis_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output pis_pkg::cmd_t pop_cmd,
    output logic          empty
);

    pis_pkg::cmd_t entry_reg [pis_pkg::QUEUE_DEPTH];

    logic [pis_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [pis_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [pis_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       do_push;
    logic                       do_pop;

    assign push_ready = (count_reg != pis_pkg::QCNT_W'(pis_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign empty      = (count_reg == '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == pis_pkg::QPTR_W'(pis_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == pis_pkg::QPTR_W'(pis_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- rtl/core/pis_back.sv -----
// ----------------------------------------------------------------------------
// pis_back
// Executes commands: owns the hold stack and emits one result per cycle
// into the output register while it is empty or res_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pis_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  pis_pkg::cmd_t             cmd,
    output logic                      res_valid,
    input  logic                      res_ready,
    output logic [1:0]                res_kind,
    output logic [31:0]               res_id,
    output logic [47:0]               res_rel_us,
    output logic                      res_last,
    output logic [pis_pkg::CNT_W-1:0] stack_cnt
);

    logic [31:0] held_ids_reg [pis_pkg::HOLD_DEPTH];

    logic [pis_pkg::CNT_W-1:0] sp_reg, sp_next;
    logic                      valid_reg, valid_next;
    logic [1:0]                kind_reg, kind_next;
    logic [31:0]               id_reg, id_next;
    logic [47:0]               rel_reg, rel_next;
    logic                      last_reg, last_next;

    logic                      load;
    logic                      step;
    logic [pis_pkg::CNT_W-1:0] sp_dec;
    logic                      push_hold;

    assign load   = !valid_reg || res_ready;
    assign step   = cmd_valid && load;
    assign sp_dec = sp_reg - 1'b1;

    assign res_valid  = valid_reg;
    assign res_kind   = kind_reg;
    assign res_id     = id_reg;
    assign res_rel_us = rel_reg;
    assign res_last   = last_reg;
    assign stack_cnt  = sp_reg;

    always_comb
    begin
        sp_next    = sp_reg;
        valid_next = valid_reg && !res_ready;
        kind_next  = kind_reg;
        id_next    = id_reg;
        rel_next   = rel_reg;
        last_next  = last_reg;
        cmd_ready  = 1'b0;
        push_hold  = 1'b0;
        if (step)
        begin
            valid_next = 1'b1;
            case (cmd.op)
                pis_pkg::CMD_HOLD:
                begin
                    kind_next = pis_pkg::VERDICT_HOLD;
                    id_next   = cmd.id;
                    rel_next  = '0;
                    last_next = 1'b1;
                    sp_next   = sp_reg + 1'b1;
                    push_hold = 1'b1;
                    cmd_ready = 1'b1;
                end
                pis_pkg::CMD_RELEASE:
                begin
                    kind_next = pis_pkg::VERDICT_RELEASE;
                    rel_next  = cmd.rel_us;
                    if (sp_reg != '0)
                    begin
                        id_next   = held_ids_reg[sp_dec[pis_pkg::PTR_W-1:0]];
                        last_next = 1'b0;
                        sp_next   = sp_dec;
                    end
                    else
                    begin
                        id_next   = cmd.id;
                        last_next = 1'b1;
                        cmd_ready = 1'b1;
                    end
                end
                default:
                begin
                    kind_next = pis_pkg::VERDICT_DROP;
                    id_next   = cmd.id;
                    rel_next  = '0;
                    last_next = 1'b1;
                    cmd_ready = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg    <= sp_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        id_reg   <= id_next;
        rel_reg  <= rel_next;
        last_reg <= last_next;
        if (push_hold)
            held_ids_reg[sp_reg[pis_pkg::PTR_W-1:0]] <= cmd.id;
    end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for packet_impairment_shaper. Packets go in on s_axis,
// verdicts come out on m_axis, and the four registers are set over APB
// between phases. A scoreboard class keeps its own copy of the loss,
// byte-window and hold-stack decisions and checks every verdict in order.
// Both stream sides idle at random. A directed run covers field extremes and
// corner cases, then random phases run with mostly time-ordered packets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
    logic [31:0] id;
    logic [47:0] arrival_us;
    logic [15:0] length;
    logic [15:0] loss_draw;
    logic [15:0] reorder_draw;
} packet_t;

typedef struct {
    logic [1:0]  kind;
    logic [31:0] id;
    logic [47:0] release_us;
    logic        last;
} verdict_t;

class verdict_scoreboard;
    logic [15:0] loss_th;
    logic [15:0] reorder_th;
    logic [31:0] byte_limit;
    logic [23:0] delay_us;
    logic [31:0] held_ids [pis_pkg::HOLD_DEPTH];
    int unsigned held_count;
    logic [32:0] window_bytes;
    logic [47:0] window_end_us;
    verdict_t    verdict_q [$];
    int unsigned errors;

    function new();
        loss_th       = '0;
        reorder_th    = '0;
        byte_limit    = '1;
        delay_us      = '0;
        held_count    = 0;
        window_bytes  = '0;
        window_end_us = '0;
        errors        = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
        case (idx)
            pis_pkg::REG_LOSS_TH:    loss_th    = value[15:0];
            pis_pkg::REG_REORDER_TH: reorder_th = value[15:0];
            pis_pkg::REG_BYTE_LIMIT: byte_limit = value;
            pis_pkg::REG_DELAY:      delay_us   = value[23:0];
            default: ;
        endcase
    endfunction

    function void add_verdict(logic [1:0] kind, logic [31:0] id, logic [47:0] rel,
                              logic last);
        verdict_t v;
        v.kind       = kind;
        v.id         = id;
        v.release_us = rel;
        v.last       = last;
        verdict_q.insert(verdict_q.size(), v);
    endfunction

    function void note_packet(packet_t p);
        logic [48:0] end_sum;
        logic [33:0] byte_sum;
        logic [47:0] rel;
        if (p.loss_draw < loss_th) begin
            add_verdict(pis_pkg::VERDICT_DROP, p.id, '0, 1'b1);
            return;
        end
        if (p.arrival_us > window_end_us) begin
            window_bytes  = '0;
            end_sum       = {1'b0, p.arrival_us} + {1'b0, pis_pkg::WINDOW_US};
            window_end_us = end_sum[48] ? '1 : end_sum[47:0];
        end
        byte_sum     = {1'b0, window_bytes} + {18'd0, p.length};
        window_bytes = byte_sum[33] ? '1 : byte_sum[32:0];
        if (window_bytes > {1'b0, byte_limit}) begin
            add_verdict(pis_pkg::VERDICT_DROP, p.id, '0, 1'b1);
            return;
        end
        if (held_count < pis_pkg::HOLD_DEPTH && p.reorder_draw < reorder_th) begin
            held_ids[held_count] = p.id;
            held_count++;
            add_verdict(pis_pkg::VERDICT_HOLD, p.id, '0, 1'b1);
            return;
        end
        rel = p.arrival_us + {24'd0, delay_us};
        while (held_count > 0) begin
            held_count--;
            add_verdict(pis_pkg::VERDICT_RELEASE, held_ids[held_count], rel, 1'b0);
        end
        add_verdict(pis_pkg::VERDICT_RELEASE, p.id, rel, 1'b1);
    endfunction

    task report_mismatch(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    task check_verdict(verdict_t got);
        verdict_t want;
        if (verdict_q.size() == 0) begin
            report_mismatch($sformatf("unexpected verdict, id %h", got.id));
            return;
        end
        want = verdict_q[0];
        verdict_q.delete(0);
        if (got.kind !== want.kind)
            report_mismatch($sformatf("id %h kind %0d, want %0d", want.id, got.kind,
                                      want.kind));
        if (got.id !== want.id)
            report_mismatch($sformatf("id %h, want %h", got.id, want.id));
        if (got.release_us !== want.release_us)
            report_mismatch($sformatf("id %h release %h, want %h", want.id,
                                      got.release_us, want.release_us));
        if (got.last !== want.last)
            report_mismatch($sformatf("id %h tlast %b, want %b", want.id, got.last,
                                      want.last));
    endtask

    function int pending();
        return verdict_q.size();
    endfunction
endclass

module testbench;

    localparam int CYCLE_LIMIT = 500000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [79:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    verdict_scoreboard sb = new();
    int unsigned       cycles = 0;
    bit                steady = 1'b0;
    bit                loss_bias = 1'b0;
    logic [47:0]       cur_us = '0;

    packet_impairment_shaper i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** packet_impairment_shaper: FAILED **");
            $finish;
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic packet_t pkt(logic [31:0] id, logic [47:0] arr, logic [15:0] len,
                                    logic [15:0] ld, logic [15:0] rd);
        packet_t p;
        p.id           = id;
        p.arrival_us   = arr;
        p.length       = len;
        p.loss_draw    = ld;
        p.reorder_draw = rd;
        return p;
    endfunction

    // mostly time-ordered traffic; some noise with arbitrary timestamps
    function automatic packet_t random_packet();
        packet_t     p;
        logic [47:0] arr;
        int          len_pick;
        p.id = $urandom;
        if ($urandom_range(0, 99) < 85)
        begin
            if ($urandom_range(0, 9) == 0)
                cur_us = cur_us + 48'($urandom_range(900000, 1100000));
            else
                cur_us = cur_us + 48'($urandom_range(0, 300000));
            p.arrival_us = cur_us;
        end
        else
        begin
            arr = {16'($urandom), 32'($urandom)};
            if (arr > cur_us)
                cur_us = arr;
            p.arrival_us = arr;
        end
        len_pick = $urandom_range(0, 9);
        if (len_pick == 0)
            p.length = '0;
        else if (len_pick == 1)
            p.length = 16'($urandom);
        else
            p.length = 16'($urandom_range(0, 1500));
        p.loss_draw    = 16'($urandom);
        p.reorder_draw = 16'($urandom);
        if (loss_bias && $urandom_range(0, 2) == 0)
            p.loss_draw = 16'hFFFF;
        return p;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_packet(packet_t p);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.reorder_draw, p.loss_draw, p.length, p.arrival_us, p.id};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_packet(p);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apb_check(logic [1:0] idx, logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            sb.report_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata,
                                         want));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // upper junk bits of the narrow registers must be ignored
    task automatic configure(logic [15:0] loss, logic [15:0] reorder, logic [31:0] limit,
                             logic [23:0] delay);
        apb_write(pis_pkg::REG_LOSS_TH, {16'($urandom), loss});
        apb_write(pis_pkg::REG_REORDER_TH, {16'($urandom), reorder});
        apb_write(pis_pkg::REG_BYTE_LIMIT, limit);
        apb_write(pis_pkg::REG_DELAY, {8'($urandom), delay});
        apb_check(pis_pkg::REG_LOSS_TH, {16'd0, loss});
        apb_check(pis_pkg::REG_REORDER_TH, {16'd0, reorder});
        apb_check(pis_pkg::REG_BYTE_LIMIT, limit);
        apb_check(pis_pkg::REG_DELAY, {8'd0, delay});
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                steady = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 59) == 0)
                wait_drained();
            send_packet(random_packet());
        end
        wait_drained();
    endtask

    initial
    begin
        forever
        begin
            verdict_t v;
            int       gap;
            @(negedge clk);
            if (rst_n)
            begin
                gap = draw_gap();
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                m_axis_tready <= 1'b1;
                do @(posedge clk); while (!m_axis_tvalid);
                v.kind       = m_axis_tuser;
                v.id         = m_axis_tdata[31:0];
                v.release_us = m_axis_tdata[79:32];
                v.last       = m_axis_tlast;
                sb.check_verdict(v);
            end
        end
    end

    initial
    begin
        logic [47:0] t0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults
        send_packet(pkt(32'h0, 48'd0, 16'd0, 16'h0, 16'h0));
        send_packet(pkt(32'hFFFF_FFFF, 48'd50, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        wait_drained();

        configure(16'h8000, 16'h8000, 32'd3000, 24'hFF_FFFF);
        t0 = 48'd2000000;
        send_packet(pkt(32'd1, t0, 16'd1000, 16'h7FFF, 16'h0));
        send_packet(pkt(32'd2, t0, 16'd1000, 16'h8000, 16'hFFFF));
        // fill the hold stack, then overflow it into a full release
        for (int k = 3; k <= 12; k++)
            send_packet(pkt(32'(k), t0 + 48'(k), 16'd100, 16'hFFFF, 16'h0));
        send_packet(pkt(32'd13, t0 + 48'd20, 16'd0, 16'hFFFF, 16'h0));
        send_packet(pkt(32'd14, t0 + 48'd30, 16'd2000, 16'hFFFF, 16'hFFFF));
        send_packet(pkt(32'd15, t0 + 48'd1000000, 16'd0, 16'hFFFF, 16'hFFFF));
        send_packet(pkt(32'd16, t0 + 48'd1000001, 16'd3000, 16'hFFFF, 16'h7FFF));
        send_packet(pkt(32'd17, t0 + 48'd1000002, 16'd0, 16'hFFFF, 16'h8000));
        send_packet(pkt(32'd18, t0 + 48'd1000003, 16'd1, 16'hFFFF, 16'h0));
        wait_drained();
        cur_us = t0 + 48'd2000000;

        configure(16'h0000, 16'h6000, 32'hFFFF_FFFF, 24'($urandom));
        run_random(85);
        configure(16'h2000, 16'hA000, 32'd6000, 24'h00_0000);
        run_random(80);
        loss_bias = 1'b1;
        configure(16'hFFFF, 16'hFFFF, 32'd0, 24'hFF_FFFF);
        run_random(80);
        loss_bias = 1'b0;
        configure(16'($urandom_range(0, 16'h3000)), 16'($urandom), $urandom,
                  24'($urandom));
        run_random(82);
        configure(16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 24'h00_0000);
        run_random(80);

        // window end saturates, release time wraps
        steady = 1'b0;
        configure(16'h0000, 16'h8000, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_packet(pkt($urandom, 48'hFFFF_FFFF_FFFA, 16'd10, 16'h0, 16'h0));
        send_packet(pkt($urandom, 48'hFFFF_FFFF_FFFF, 16'd10, 16'h0, 16'hFFFF));
        send_packet(pkt($urandom, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'h0, 16'hFFFF));
        wait_drained();

        repeat (20) @(negedge clk);
        if (sb.errors == 0)
            $display("** packet_impairment_shaper: PASSED **");
        else
            $display("** packet_impairment_shaper: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/pis_pkg.sv
rtl/core/pis_front.sv
rtl/core/pis_queue.sv
rtl/core/pis_back.sv
rtl/core/packet_impairment_shaper.sv
bench/testbench.sv
